### rtl/core/zstd_frame_header_parser_defines.svh
// ----------------------------------------------------------------------------
// zstd frame header parser assertion macros
// shared concurrent assertion forms for the header parser
// ----------------------------------------------------------------------------
`ifndef ZSTD_FRAME_HEADER_PARSER_DEFINES_SVH
`define ZSTD_FRAME_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ZFHP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zfhp same-cycle check failed");

// next-cycle implication, disabled during reset
`define ZFHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zfhp next-cycle check failed");

`endif

### rtl/core/zfhp_pkg.sv
// ----------------------------------------------------------------------------
// zfhp_pkg
// types, constants and decode functions for the frame header parser
// ----------------------------------------------------------------------------
package zfhp_pkg;

    localparam logic [31:0] MAGIC_NORMAL    = 32'hFD2FB528;
    localparam logic [27:0] MAGIC_SKIP_HI   = 28'h184D2A5;
    localparam logic [5:0]  WINDOW_LOG_MIN  = 6'd10;
    localparam logic [63:0] SHORT_SIZE_BIAS = 64'd256;
    localparam logic [17:0] CAP_RESET       = 18'd131072;

    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_SKIP   = 2'd1;
    localparam logic [1:0] KIND_BAD    = 2'd2;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_MAGIC    = 7'b0000010,
        PH_SKIPSIZE = 7'b0000100,
        PH_DESC     = 7'b0001000,
        PH_WIN      = 7'b0010000,
        PH_DICT     = 7'b0100000,
        PH_FCS      = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [63:0] window_size;
        logic [63:0] content_size;
        logic        content_size_present;
        logic [31:0] dictionary_id;
        logic        checksum_present;
        logic        single_segment;
        logic [17:0] block_max_size;
        logic [31:0] skip_length;
    } result_t;

    function automatic logic [3:0] dict_len(input logic [7:0] d);
        logic [3:0] len;
        case (d[1:0])
            2'd0:    len = 4'd0;
            2'd1:    len = 4'd1;
            2'd2:    len = 4'd2;
            default: len = 4'd4;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] fcs_len(input logic [7:0] d);
        logic [3:0] len;
        case (d[7:6])
            2'd0:    len = d[5] ? 4'd1 : 4'd0;
            2'd1:    len = 4'd2;
            2'd2:    len = 4'd4;
            default: len = 4'd8;
        endcase
        return len;
    endfunction

    // base plus mantissa eighths of base; base is a power of two
    function automatic logic [63:0] window_decode(input logic [7:0] w);
        logic [5:0]  expo;
        logic [63:0] base;
        logic [63:0] frac;
        expo = {1'b0, w[7:3]};
        base = 64'd1 << (expo + WINDOW_LOG_MIN);
        frac = {61'd0, w[2:0]} << (expo + WINDOW_LOG_MIN - 6'd3);
        return base + frac;
    endfunction

endpackage

### rtl/core/zfhp_parse_core.sv
// ----------------------------------------------------------------------------
// zfhp_parse_core
// per-byte header state update and result decode
// ----------------------------------------------------------------------------
module zfhp_parse_core import zfhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [17:0] cfg_wdata,
    input  logic        byte_fire,
    input  logic [7:0]  data_byte,
    input  logic        frame_start,
    output logic        emit,
    output result_t     result
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] magic_reg, magic_next;
    logic [7:0]  desc_reg, desc_next;
    logic [7:0]  win_reg, win_next;
    logic [31:0] dict_reg, dict_next;
    logic [63:0] size_reg, size_next;
    logic [17:0] cap_reg;

    phase_t      ph;
    logic [3:0]  cnt;
    logic [31:0] magic;
    logic [7:0]  desc;
    logic [7:0]  win;
    logic [31:0] dict;
    logic [63:0] size;
    logic        go_dict, go_fcs, go_emit;
    logic [3:0]  flen;
    logic [63:0] content;
    logic [63:0] window;

    always_comb
    begin
        ph    = frame_start ? PH_MAGIC : phase_reg;
        cnt   = frame_start ? 4'd0 : cnt_reg;
        magic = frame_start ? 32'd0 : magic_reg;
        desc  = frame_start ? 8'd0 : desc_reg;
        win   = frame_start ? 8'd0 : win_reg;
        dict  = frame_start ? 32'd0 : dict_reg;
        size  = frame_start ? 64'd0 : size_reg;

        phase_next = ph;
        cnt_next   = cnt;
        magic_next = magic;
        desc_next  = desc;
        win_next   = win;
        dict_next  = dict;
        size_next  = size;
        go_dict    = 1'b0;
        go_fcs     = 1'b0;
        go_emit    = 1'b0;
        emit       = 1'b0;
        result     = '0;

        case (ph)
            PH_MAGIC:
            begin
                magic_next = magic | ({24'd0, data_byte} << {cnt[1:0], 3'd0});
                cnt_next   = cnt + 4'd1;
                if (cnt_next >= 4'd4)
                begin
                    cnt_next = 4'd0;
                    if (magic_next == MAGIC_NORMAL)
                    begin
                        phase_next = PH_DESC;
                    end
                    else if (magic_next[31:4] == MAGIC_SKIP_HI)
                    begin
                        phase_next = PH_SKIPSIZE;
                    end
                    else
                    begin
                        phase_next        = PH_IDLE;
                        emit              = 1'b1;
                        result.frame_kind = KIND_BAD;
                    end
                end
            end
            PH_SKIPSIZE:
            begin
                dict_next = dict | ({24'd0, data_byte} << {cnt[1:0], 3'd0});
                cnt_next  = cnt + 4'd1;
                if (cnt_next >= 4'd4)
                begin
                    phase_next         = PH_IDLE;
                    emit               = 1'b1;
                    result.frame_kind  = KIND_SKIP;
                    result.skip_length = dict_next;
                end
            end
            PH_DESC:
            begin
                desc_next = data_byte;
                if (!data_byte[5])
                begin
                    phase_next = PH_WIN;
                end
                else
                begin
                    go_dict = 1'b1;
                end
            end
            PH_WIN:
            begin
                win_next = data_byte;
                go_dict  = 1'b1;
            end
            PH_DICT:
            begin
                dict_next = dict | ({24'd0, data_byte} << {cnt[1:0], 3'd0});
                cnt_next  = cnt + 4'd1;
                if (cnt_next >= dict_len(desc))
                begin
                    go_fcs = 1'b1;
                end
            end
            PH_FCS:
            begin
                size_next = size | ({56'd0, data_byte} << {cnt[2:0], 3'd0});
                cnt_next  = cnt + 4'd1;
                if (cnt_next >= fcs_len(desc))
                begin
                    go_emit = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (go_dict)
        begin
            cnt_next = 4'd0;
            if (dict_len(desc_next) != 4'd0)
            begin
                phase_next = PH_DICT;
            end
            else
            begin
                go_fcs = 1'b1;
            end
        end

        if (go_fcs)
        begin
            cnt_next = 4'd0;
            if (fcs_len(desc_next) != 4'd0)
            begin
                phase_next = PH_FCS;
            end
            else
            begin
                go_emit = 1'b1;
            end
        end

        flen    = fcs_len(desc_next);
        content = 64'd0;
        if (flen != 4'd0)
        begin
            content = size_next + ((flen == 4'd2) ? SHORT_SIZE_BIAS : 64'd0);
        end
        window = desc_next[5] ? content : window_decode(win_next);

        if (go_emit)
        begin
            phase_next                  = PH_IDLE;
            emit                        = 1'b1;
            result.frame_kind           = KIND_NORMAL;
            result.window_size          = window;
            result.content_size         = content;
            result.content_size_present = (flen != 4'd0);
            result.dictionary_id        = dict_next;
            result.checksum_present     = desc_next[2];
            result.single_segment       = desc_next[5];
            result.block_max_size       = ((window[63:18] == 46'd0) && (window[17:0] < cap_reg))
                                          ? window[17:0] : cap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 4'd0;
            magic_reg <= 32'd0;
            desc_reg  <= 8'd0;
            win_reg   <= 8'd0;
            dict_reg  <= 32'd0;
            size_reg  <= 64'd0;
        end
        else if (byte_fire)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            magic_reg <= magic_next;
            desc_reg  <= desc_next;
            win_reg   <= win_next;
            dict_reg  <= dict_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

endmodule

### rtl/core/zfhp_result_reg.sv
// ----------------------------------------------------------------------------
// zfhp_result_reg
// output register holding one header result until transfer
// ----------------------------------------------------------------------------
module zfhp_result_reg import zfhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    output logic    slot_free,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result_out
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign slot_free    = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result_out   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

### rtl/core/zstd_frame_header_parser.sv
// output: a header result is registered and shown in the cycle after the transfer of its last header byte
// throughput: one byte per cycle while byte_ready is high, the state is updated once per accepted byte
// the byte channel stalls only while a finished result waits and result_ready is low
// reset: rst_n asynchronous active low, parser idle until the next frame start byte
// reset: block size cap returns to 131072, output register empty
// ----------------------------------------------------------------------------
// zstd_frame_header_parser
// frame header parser top level: magic check, descriptor and field decode
// ----------------------------------------------------------------------------
`include "zstd_frame_header_parser_defines.svh"

module zstd_frame_header_parser import zfhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [17:0] cfg_wdata,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_start,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  frame_kind,
    output logic [63:0] window_size,
    output logic [63:0] content_size,
    output logic        content_size_present,
    output logic [31:0] dictionary_id,
    output logic        checksum_present,
    output logic        single_segment,
    output logic [17:0] block_max_size,
    output logic [31:0] skip_length
);

    logic    byte_fire;
    logic    emit;
    result_t core_result;
    result_t out_result;

    assign byte_fire = byte_valid && byte_ready;

    zfhp_parse_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .byte_fire   (byte_fire),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .emit        (emit),
        .result      (core_result)
    );

    zfhp_result_reg u_result
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (byte_fire && emit),
        .result_in    (core_result),
        .slot_free    (byte_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_out   (out_result)
    );

    assign frame_kind           = out_result.frame_kind;
    assign window_size          = out_result.window_size;
    assign content_size         = out_result.content_size;
    assign content_size_present = out_result.content_size_present;
    assign dictionary_id        = out_result.dictionary_id;
    assign checksum_present     = out_result.checksum_present;
    assign single_segment       = out_result.single_segment;
    assign block_max_size       = out_result.block_max_size;
    assign skip_length          = out_result.skip_length;

    `ZFHP_ASSERT_SAME(a_non_normal_zero, clk, rst_n,
        result_valid && (frame_kind != KIND_NORMAL),
        (window_size == 64'd0) && (content_size == 64'd0) && (dictionary_id == 32'd0))
    `ZFHP_ASSERT_SAME(a_single_seg_window, clk, rst_n,
        result_valid && (frame_kind == KIND_NORMAL) && single_segment,
        window_size == content_size)
    `ZFHP_ASSERT_SAME(a_rise_after_transfer, clk, rst_n,
        $rose(result_valid),
        $past(byte_valid && byte_ready))

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// byte-stream test of the frame header parser: directed frames, then random
// normal, skippable, bad-magic, cut-short and noise traffic under several
// block size caps, each header result checked field by field in order
// ----------------------------------------------------------------------------
module tb import zfhp_pkg::*; ();

    localparam int IDLE_LIMIT = 400;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [17:0] cfg_wdata = '0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  data_byte = '0;
    logic        frame_start = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [1:0]  frame_kind;
    logic [63:0] window_size;
    logic [63:0] content_size;
    logic        content_size_present;
    logic [31:0] dictionary_id;
    logic        checksum_present;
    logic        single_segment;
    logic [17:0] block_max_size;
    logic [31:0] skip_length;

    zstd_frame_header_parser dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .byte_valid           (byte_valid),
        .byte_ready           (byte_ready),
        .data_byte            (data_byte),
        .frame_start          (frame_start),
        .result_valid         (result_valid),
        .result_ready         (result_ready),
        .frame_kind           (frame_kind),
        .window_size          (window_size),
        .content_size         (content_size),
        .content_size_present (content_size_present),
        .dictionary_id        (dictionary_id),
        .checksum_present     (checksum_present),
        .single_segment       (single_segment),
        .block_max_size       (block_max_size),
        .skip_length          (skip_length)
    );

    function automatic int id_field_len(input logic [7:0] d);
        case (d[1:0])
            2'd0:    return 0;
            2'd1:    return 1;
            2'd2:    return 2;
            default: return 4;
        endcase
    endfunction

    function automatic int size_field_len(input logic [7:0] d);
        case (d[7:6])
            2'd0:    return d[5] ? 1 : 0;
            2'd1:    return 2;
            2'd2:    return 4;
            default: return 8;
        endcase
    endfunction

    class header_scoreboard;
        phase_t      stage;
        logic [3:0]  got_bytes;
        logic [31:0] magic_word;
        logic [7:0]  descriptor;
        logic [7:0]  window_desc;
        logic [31:0] id_word;
        logic [63:0] size_word;
        logic [17:0] cap;
        result_t     expected_headers[$];
        int          errors;

        function new();
            stage       = PH_IDLE;
            got_bytes   = '0;
            magic_word  = '0;
            descriptor  = '0;
            window_desc = '0;
            id_word     = '0;
            size_word   = '0;
            cap         = CAP_RESET;
            errors      = 0;
        endfunction

        function void push_plain(input logic [1:0] kind, input logic [31:0] skip);
            result_t r;
            r             = '0;
            r.frame_kind  = kind;
            r.skip_length = skip;
            expected_headers.push_back(r);
            stage = PH_IDLE;
        endfunction

        function void finish_normal();
            result_t     r;
            int          n;
            logic [63:0] base;
            n = size_field_len(descriptor);
            r = '0;
            r.frame_kind = KIND_NORMAL;
            if (n != 0)
            begin
                r.content_size         = (n == 2) ? size_word + SHORT_SIZE_BIAS : size_word;
                r.content_size_present = 1'b1;
            end
            if (descriptor[5])
                r.window_size = r.content_size;
            else
            begin
                base          = 64'd1 << (int'(window_desc[7:3]) + 10);
                r.window_size = base + (base >> 3) * window_desc[2:0];
            end
            if (r.window_size < 64'(cap))
                r.block_max_size = r.window_size[17:0];
            else
                r.block_max_size = cap;
            r.dictionary_id    = id_word;
            r.checksum_present = descriptor[2];
            r.single_segment   = descriptor[5];
            expected_headers.push_back(r);
            stage = PH_IDLE;
        endfunction

        function void open_size_field();
            got_bytes = '0;
            if (size_field_len(descriptor) != 0)
                stage = PH_FCS;
            else
                finish_normal();
        endfunction

        function void open_id_field();
            got_bytes = '0;
            if (id_field_len(descriptor) != 0)
                stage = PH_DICT;
            else
                open_size_field();
        endfunction

        // one accepted byte transfer
        function void note_byte(input logic [7:0] b, input logic s);
            int sh;
            if (s)
            begin
                stage       = PH_MAGIC;
                got_bytes   = '0;
                magic_word  = '0;
                descriptor  = '0;
                window_desc = '0;
                id_word     = '0;
                size_word   = '0;
            end
            sh = 8 * int'(got_bytes[2:0]);
            case (stage)
                PH_MAGIC:
                begin
                    magic_word = magic_word | (32'(b) << sh);
                    got_bytes  = got_bytes + 4'd1;
                    if (got_bytes == 4'd4)
                    begin
                        got_bytes = '0;
                        if (magic_word == MAGIC_NORMAL)
                            stage = PH_DESC;
                        else if (magic_word[31:4] == MAGIC_SKIP_HI)
                            stage = PH_SKIPSIZE;
                        else
                            push_plain(KIND_BAD, '0);
                    end
                end
                PH_SKIPSIZE:
                begin
                    id_word   = id_word | (32'(b) << sh);
                    got_bytes = got_bytes + 4'd1;
                    if (got_bytes == 4'd4)
                        push_plain(KIND_SKIP, id_word);
                end
                PH_DESC:
                begin
                    descriptor = b;
                    if (!b[5])
                        stage = PH_WIN;
                    else
                        open_id_field();
                end
                PH_WIN:
                begin
                    window_desc = b;
                    open_id_field();
                end
                PH_DICT:
                begin
                    id_word   = id_word | (32'(b) << sh);
                    got_bytes = got_bytes + 4'd1;
                    if (int'(got_bytes) >= id_field_len(descriptor))
                        open_size_field();
                end
                PH_FCS:
                begin
                    size_word = size_word | (64'(b) << sh);
                    got_bytes = got_bytes + 4'd1;
                    if (int'(got_bytes) >= size_field_len(descriptor))
                        finish_normal();
                end
                default:
                    stage = PH_IDLE;
            endcase
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 100)
                $display("[%0t] header mismatch: %s", $time, what);
        endtask

        task compare_field(input string name, input logic [63:0] got, input logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // one accepted result transfer
        task check_header(input result_t got);
            result_t want;
            if (expected_headers.size() == 0)
            begin
                report("header result with none expected");
                return;
            end
            want = expected_headers.pop_front();
            compare_field("frame_kind", 64'(got.frame_kind), 64'(want.frame_kind));
            compare_field("window_size", got.window_size, want.window_size);
            compare_field("content_size", got.content_size, want.content_size);
            compare_field("content_size_present", 64'(got.content_size_present),
                          64'(want.content_size_present));
            compare_field("dictionary_id", 64'(got.dictionary_id), 64'(want.dictionary_id));
            compare_field("checksum_present", 64'(got.checksum_present),
                          64'(want.checksum_present));
            compare_field("single_segment", 64'(got.single_segment),
                          64'(want.single_segment));
            compare_field("block_max_size", 64'(got.block_max_size),
                          64'(want.block_max_size));
            compare_field("skip_length", 64'(got.skip_length), 64'(want.skip_length));
        endtask
    endclass

    header_scoreboard sb = new();

    logic [7:0]  frame_bytes[$];
    int          header_bytes_sent = 0;
    int          in_left = 0;
    bit          in_quiet = 0;
    int          out_left = 0;
    bit          out_quiet = 0;
    int          idle_cycles = 0;
    logic [17:0] cap_plan[8];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // stretches of back-to-back transfers and stretches with random waits follow in random order
    function automatic int draw_wait(ref int left, ref bit quiet);
        if (left == 0)
        begin
            left  = $urandom_range(10, 60);
            quiet = ($urandom_range(0, 3) == 0);
        end
        left--;
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic void put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            frame_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void build_magic(input logic [31:0] m);
        frame_bytes.delete();
        put_le(64'(m), 4);
    endfunction

    function automatic void build_skip(input logic [3:0] nib, input logic [31:0] len);
        build_magic({MAGIC_SKIP_HI, nib});
        put_le(64'(len), 4);
    endfunction

    function automatic void build_normal(input logic [7:0] desc, input logic [7:0] win,
                                         input logic [31:0] id, input logic [63:0] fcs);
        build_magic(MAGIC_NORMAL);
        frame_bytes.push_back(desc);
        if (!desc[5])
            frame_bytes.push_back(win);
        put_le(64'(id), id_field_len(desc));
        put_le(fcs, size_field_len(desc));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s);
        int pause;
        pause = draw_wait(in_left, in_quiet);
        if (pause > 0)
        begin
            byte_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        byte_valid  <= 1'b1;
        data_byte   <= b;
        frame_start <= s;
        do @(posedge clk); while (!byte_ready);
        sb.note_byte(b, s);
    endtask

    task automatic send_frame(input int keep);
        for (int i = 0; i < frame_bytes.size() && i < keep; i++)
        begin
            send_byte(frame_bytes[i], i == 0);
            header_bytes_sent++;
        end
    endtask

    task automatic set_cap(input logic [17:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.cap = v;
    endtask

    task automatic settle();
        byte_valid <= 1'b0;
        while (sb.expected_headers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_frame();
        int         pick;
        int         keep;
        logic [7:0] desc;
        logic [7:0] win;
        pick = $urandom_range(0, 99);
        desc = 8'($urandom);
        win  = 8'($urandom);
        if ($urandom_range(0, 1) == 1)
            win[7:3] = 5'($urandom_range(0, 8));
        if (pick < 12)
        begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
            return;
        end
        if (pick < 72)
            build_normal(desc, win, $urandom, {$urandom, $urandom});
        else if (pick < 86)
            build_skip(4'($urandom), $urandom);
        else if (pick < 93)
            build_magic($urandom);
        else
            build_magic(((pick % 2) ? MAGIC_NORMAL : {MAGIC_SKIP_HI, 4'h0})
                        ^ (32'd1 << $urandom_range(0, 31)));
        if ($urandom_range(0, 9) == 0)
            keep = $urandom_range(1, frame_bytes.size() - 1);
        else
            keep = frame_bytes.size();
        send_frame(keep);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
    endtask

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(out_left, out_quiet);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            sb.check_header({frame_kind, window_size, content_size, content_size_present,
                             dictionary_id, checksum_present, single_segment,
                             block_max_size, skip_length});

    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        cap_plan = '{18'd1, 18'd0, 18'h3FFFF, CAP_RESET, 18'($urandom_range(1, 131072)),
                     18'd1024, 18'($urandom_range(0, 262143)), 18'($urandom_range(1, 4096))};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_cap(CAP_RESET);

        // bytes with no frame start are dropped while idle
        repeat (3) send_byte(8'($urandom), 1'b0);
        build_magic(32'h0000_0000);
        send_frame(99);
        build_magic(32'hFFFF_FFFF);
        send_frame(99);
        build_magic(MAGIC_NORMAL ^ 32'h8000_0000);
        send_frame(99);
        build_normal(8'h00, 8'h00, '0, '0);
        send_frame(99);
        build_normal(8'h00, 8'hFF, '0, '0);
        send_frame(99);
        build_normal(8'h1C, 8'h57, '0, '0);
        send_frame(99);
        build_normal(8'h20, 8'h00, '0, 64'h00);
        send_frame(99);
        build_normal(8'h20, 8'h00, '0, 64'hFF);
        send_frame(99);
        build_normal(8'h40, 8'h38, '0, 64'hFFFF);
        send_frame(99);
        build_normal(8'h60, 8'h00, '0, 64'h0000);
        send_frame(99);
        build_normal(8'h81, 8'h48, 32'hA5, 64'hFFFF_FFFF);
        send_frame(99);
        build_normal(8'hE2, 8'h00, 32'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(99);
        build_normal(8'hC3, 8'hFF, 32'hFFFF_FFFF, 64'h1);
        send_frame(99);
        repeat (3) send_byte(8'($urandom), 1'b0);
        build_skip(4'h0, 32'h0);
        send_frame(99);
        build_skip(4'hF, 32'hFFFF_FFFF);
        send_frame(99);

        // a new frame start cuts short the header in progress
        build_normal(8'hC3, 8'h6A, 32'h1234_5678, 64'h0123_4567_89AB_CDEF);
        send_frame(2);
        send_frame(8);
        send_frame(14);
        build_skip(4'h7, 32'h00C0_FFEE);
        send_frame(6);
        build_normal(8'h83, 8'h6A, 32'h1234_5678, 64'h0123_4567_89AB_CDEF);
        send_frame(99);

        header_bytes_sent = 0;
        foreach (cap_plan[i])
        begin
            settle();
            set_cap(cap_plan[i]);
            while (header_bytes_sent < 145 * (i + 1))
                random_frame();
        end
        settle();

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
